// File: src/ocp_pkg.sv
// ----------------------------------------------------------------------------
// ocp_pkg
// Shared constants, codes, arctangent table and the job record passed from
// the command front end to the position back end.
// ----------------------------------------------------------------------------
package ocp_pkg;

  localparam int AngleBitsDef    = 24;
  localparam int FracBitsDef     = 16;
  localparam int CordicStagesDef = 18;
  localparam int TableLen        = 30;
  localparam int QueueDepth      = 2;

  localparam logic [15:0] RotGainRst   = 16'd13352;
  localparam logic [21:0] PitchLimRst  = 22'd3927286;
  localparam logic [33:0] GainQ30      = 34'd652032874;

  typedef enum logic [1:0] {
    CMD_MOTION = 2'd0,
    CMD_TARGET = 2'd1,
    CMD_INIT   = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    CFG_ROT_GAIN  = 2'd0,
    CFG_PITCH_LIM = 2'd1,
    CFG_ZOOM_GAIN = 2'd2,
    CFG_MIN_DIST  = 2'd3
  } cfg_idx_e;

  // angles in 32-bit turn units
  typedef struct packed {
    logic [31:0]        yaw_t;
    logic [31:0]        pitch_t;
    logic [31:0]        dist_v;
    logic signed [31:0] tx;
    logic signed [31:0] ty;
    logic signed [31:0] tz;
    logic               clamped;
  } job_t;

  function automatic logic [29:0] atan_turn(input logic [4:0] i);
    logic [29:0] r;
    case (i)
      5'd0:  r = 30'd536870912;
      5'd1:  r = 30'd316933406;
      5'd2:  r = 30'd167458907;
      5'd3:  r = 30'd85004756;
      5'd4:  r = 30'd42667331;
      5'd5:  r = 30'd21354465;
      5'd6:  r = 30'd10679838;
      5'd7:  r = 30'd5340245;
      5'd8:  r = 30'd2670163;
      5'd9:  r = 30'd1335087;
      5'd10: r = 30'd667544;
      5'd11: r = 30'd333772;
      5'd12: r = 30'd166886;
      5'd13: r = 30'd83443;
      5'd14: r = 30'd41722;
      5'd15: r = 30'd20861;
      5'd16: r = 30'd10430;
      5'd17: r = 30'd5215;
      5'd18: r = 30'd2608;
      5'd19: r = 30'd1304;
      5'd20: r = 30'd652;
      5'd21: r = 30'd326;
      5'd22: r = 30'd163;
      5'd23: r = 30'd81;
      5'd24: r = 30'd41;
      5'd25: r = 30'd20;
      5'd26: r = 30'd10;
      5'd27: r = 30'd5;
      5'd28: r = 30'd3;
      5'd29: r = 30'd1;
      default: r = 30'd0;
    endcase
    return r;
  endfunction

endpackage

// File: src/orbit_camera_position.sv
// ----------------------------------------------------------------------------
// orbit_camera_position
// Orbit camera state and spherical-to-cartesian position output.
// ----------------------------------------------------------------------------
// The back end handles one item at a time through its rotate, multiply and sum
// states, and stalls in the sum state while the output is held; a two-entry
// queue lets the front take items while the back is busy.
// Reset: asynchronous, active low; state and registers return to defaults.
module orbit_camera_position #(
  parameter int ANGLE_BITS    = ocp_pkg::AngleBitsDef,
  parameter int FRAC_BITS     = ocp_pkg::FracBitsDef,
  parameter int CORDIC_STAGES = ocp_pkg::CordicStagesDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_addr_i,
  input  logic [31:0]  cfg_wdata_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // mouse_dx, mouse_dy, wheel_delta, target_x, target_y, target_z, init_distance
  input  logic [175:0] s_axis_tdata,
  // cmd
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // pos_x, pos_y, pos_z
  output logic [95:0]  m_axis_tdata,
  // pitch_clamped
  output logic [0:0]   m_axis_tuser
);
  import ocp_pkg::*;

  job_t               job_in, job_out;
  logic               push, pop, full, empty, clamped;
  logic signed [31:0] px, py, pz;

  assign s_axis_tready = !full;
  assign push          = s_axis_tvalid && s_axis_tready;

  ocp_front #(.ANGLE_BITS(ANGLE_BITS), .FRAC_BITS(FRAC_BITS)) u_front (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_addr_i, .cfg_wdata_i,
    .push_i (push),
    .cmd_i  (cmd_e'(s_axis_tuser)),
    .dx_i   ($signed(s_axis_tdata[15:0])),
    .dy_i   ($signed(s_axis_tdata[31:16])),
    .wh_i   ($signed(s_axis_tdata[47:32])),
    .tx_i   ($signed(s_axis_tdata[79:48])),
    .ty_i   ($signed(s_axis_tdata[111:80])),
    .tz_i   ($signed(s_axis_tdata[143:112])),
    .initd_i(s_axis_tdata[175:144]),
    .job_o  (job_in)
  );

  ocp_queue u_queue (
    .clk_i, .rst_ni,
    .push_i (push),
    .job_i  (job_in),
    .pop_i  (pop),
    .job_o  (job_out),
    .full_o (full),
    .empty_o(empty)
  );

  ocp_back #(.CORDIC_STAGES(CORDIC_STAGES)) u_back (
    .clk_i, .rst_ni,
    .job_i    (job_out),
    .empty_i  (empty),
    .pop_o    (pop),
    .valid_o  (m_axis_tvalid),
    .ready_i  (m_axis_tready),
    .pos_x_o  (px),
    .pos_y_o  (py),
    .pos_z_o  (pz),
    .clamped_o(clamped)
  );

  assign m_axis_tdata = {pz, py, px};
  assign m_axis_tuser = clamped;

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !empty) else $error("pop from empty queue");

  a_pitch_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> ($signed(job_in.pitch_t) <= 32'sd1073741824 &&
              $signed(job_in.pitch_t) >= -32'sd1073741824))
    else $error("pitch beyond a quarter turn");

  a_clamp_motion: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && job_in.clamped) |-> (s_axis_tuser == CMD_MOTION))
    else $error("clamp flag on a non-motion item");

endmodule

// File: src/ocp_front.sv
// ----------------------------------------------------------------------------
// ocp_front
// Configuration registers and camera state. Applies each accepted item to
// the state and hands a job record to the queue in the same cycle.
// ----------------------------------------------------------------------------
module ocp_front #(
  parameter int ANGLE_BITS = 24,
  parameter int FRAC_BITS  = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_addr_i,
  input  logic [31:0]        cfg_wdata_i,
  input  logic               push_i,
  input  ocp_pkg::cmd_e      cmd_i,
  input  logic signed [15:0] dx_i,
  input  logic signed [15:0] dy_i,
  input  logic signed [15:0] wh_i,
  input  logic signed [31:0] tx_i,
  input  logic signed [31:0] ty_i,
  input  logic signed [31:0] tz_i,
  input  logic [31:0]        initd_i,
  output ocp_pkg::job_t      job_o
);
  import ocp_pkg::*;

  localparam int PW = 35;

  logic [15:0]           rot_gain_q;
  logic [21:0]           pitch_lim_q;
  logic [23:0]           zoom_gain_q;
  logic [31:0]           min_dist_q;
  logic [ANGLE_BITS-1:0] yaw_q, yaw_d, pitch_q, pitch_d;
  logic [31:0]           dist_q, dist_d;
  logic signed [31:0]    tx_q, tx_d, ty_q, ty_d, tz_q, tz_d;

  logic signed [32:0]    yaw_prod, pitch_prod;
  logic signed [PW-1:0]  pitch_sum, pitch_c, lim, quarter;
  logic                  clamp;
  logic signed [40:0]    zoom_prod;
  logic signed [41:0]    nd;
  logic [31:0]           dist_m;

  always_comb begin
    yaw_prod   = $signed(33'(dx_i)) * $signed({17'b0, rot_gain_q});
    pitch_prod = $signed(33'(dy_i)) * $signed({17'b0, rot_gain_q});
    pitch_sum  = PW'($signed(pitch_q)) + PW'(pitch_prod);
    quarter    = PW'(1) <<< (ANGLE_BITS - 2);
    lim        = ($signed({13'b0, pitch_lim_q}) > quarter) ? quarter
                                                           : $signed({13'b0, pitch_lim_q});
    clamp      = 1'b0;
    pitch_c    = pitch_sum;
    if (pitch_sum > lim) begin
      pitch_c = lim;
      clamp   = 1'b1;
    end else if (pitch_sum < -lim) begin
      pitch_c = -lim;
      clamp   = 1'b1;
    end
    zoom_prod = $signed(41'(wh_i)) * $signed({17'b0, zoom_gain_q});
    nd        = $signed({10'b0, dist_q}) - 42'(zoom_prod);
    if (nd < $signed({10'b0, min_dist_q})) begin
      dist_m = min_dist_q;
    end else if (nd > $signed({10'b0, 32'hFFFF_FFFF})) begin
      dist_m = 32'hFFFF_FFFF;
    end else begin
      dist_m = nd[31:0];
    end

    yaw_d   = yaw_q;
    pitch_d = pitch_q;
    dist_d  = dist_q;
    tx_d    = tx_q;
    ty_d    = ty_q;
    tz_d    = tz_q;
    case (cmd_i)
      CMD_MOTION: begin
        yaw_d   = yaw_q + yaw_prod[ANGLE_BITS-1:0];
        pitch_d = pitch_c[ANGLE_BITS-1:0];
        dist_d  = dist_m;
      end
      CMD_TARGET: begin
        tx_d = tx_i;
        ty_d = ty_i;
        tz_d = tz_i;
      end
      CMD_INIT: begin
        tx_d    = tx_i;
        ty_d    = ty_i;
        tz_d    = tz_i;
        dist_d  = initd_i;
        yaw_d   = '0;
        pitch_d = '0;
      end
      default: ;
    endcase

    job_o.yaw_t   = 32'(yaw_d) << (32 - ANGLE_BITS);
    job_o.pitch_t = 32'(pitch_d) << (32 - ANGLE_BITS);
    job_o.dist_v  = dist_d;
    job_o.tx      = tx_d;
    job_o.ty      = ty_d;
    job_o.tz      = tz_d;
    job_o.clamped = (cmd_i == CMD_MOTION) && clamp;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rot_gain_q  <= RotGainRst;
      pitch_lim_q <= PitchLimRst;
      zoom_gain_q <= 24'(1) << FRAC_BITS;
      min_dist_q  <= 32'(1) << FRAC_BITS;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_addr_i))
        CFG_ROT_GAIN:  rot_gain_q  <= cfg_wdata_i[15:0];
        CFG_PITCH_LIM: pitch_lim_q <= cfg_wdata_i[21:0];
        CFG_ZOOM_GAIN: zoom_gain_q <= cfg_wdata_i[23:0];
        CFG_MIN_DIST:  min_dist_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      yaw_q   <= '0;
      pitch_q <= '0;
      dist_q  <= 32'(5) << FRAC_BITS;
      tx_q    <= '0;
      ty_q    <= '0;
      tz_q    <= '0;
    end else if (push_i) begin
      yaw_q   <= yaw_d;
      pitch_q <= pitch_d;
      dist_q  <= dist_d;
      tx_q    <= tx_d;
      ty_q    <= ty_d;
      tz_q    <= tz_d;
    end
  end

endmodule

// File: src/ocp_queue.sv
// ----------------------------------------------------------------------------
// ocp_queue
// Small FIFO of job records between front end and back end.
// ----------------------------------------------------------------------------
module ocp_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  ocp_pkg::job_t job_i,
  input  logic          pop_i,
  output ocp_pkg::job_t job_o,
  output logic          full_o,
  output logic          empty_o
);
  import ocp_pkg::*;

  localparam int PtrW = $clog2(QueueDepth);

  job_t              mem_q [QueueDepth];
  logic [PtrW-1:0]   wr_q, rd_q;
  logic [PtrW:0]     cnt_q;

  assign full_o  = (cnt_q == (PtrW+1)'(QueueDepth));
  assign empty_o = (cnt_q == '0);
  assign job_o   = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == PtrW'(QueueDepth - 1)) ? '0 : rd_q + 1'b1;
      end
      cnt_q <= cnt_q + (PtrW+1)'(push_i) - (PtrW+1)'(pop_i);
    end
  end

endmodule

// File: src/ocp_cordic.sv
// ----------------------------------------------------------------------------
// ocp_cordic
// Iterative sine/cosine rotator, one micro-rotation per cycle, Q2.30.
// ----------------------------------------------------------------------------
module ocp_cordic #(
  parameter int CORDIC_STAGES = 18
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [31:0]        angle_i,
  output logic               done_o,
  output logic signed [34:0] sin_o,
  output logic signed [34:0] cos_o
);
  import ocp_pkg::*;

  localparam int Stages = (CORDIC_STAGES > TableLen) ? TableLen : CORDIC_STAGES;
  localparam int IW     = $clog2(Stages);

  logic signed [34:0] x_q, y_q;
  logic signed [33:0] z_q, z0;
  logic               flip_q, flip0, busy_q, done_q;
  logic [IW-1:0]      cnt_q;
  logic signed [33:0] at;

  always_comb begin
    z0    = 34'($signed(angle_i));
    flip0 = 1'b0;
    if (z0 > 34'sd1073741824) begin
      z0    = z0 - 34'sd2147483648;
      flip0 = 1'b1;
    end else if (z0 < -34'sd1073741824) begin
      z0    = z0 + 34'sd2147483648;
      flip0 = 1'b1;
    end
    at = $signed({4'b0, atan_turn(5'(cnt_q))});
  end

  assign sin_o  = flip_q ? -y_q : y_q;
  assign cos_o  = flip_q ? -x_q : x_q;
  assign done_o = done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        if (cnt_q == IW'(Stages - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q    <= $signed({1'b0, GainQ30});
      y_q    <= '0;
      z_q    <= z0;
      flip_q <= flip0;
    end else if (busy_q) begin
      if (z_q >= 0) begin
        x_q <= x_q - (y_q >>> cnt_q);
        y_q <= y_q + (x_q >>> cnt_q);
        z_q <= z_q - at;
      end else begin
        x_q <= x_q + (y_q >>> cnt_q);
        y_q <= y_q - (x_q >>> cnt_q);
        z_q <= z_q + at;
      end
    end
  end

endmodule

// File: src/ocp_back.sv
// ----------------------------------------------------------------------------
// ocp_back
// Takes a job from the queue, runs yaw and pitch rotators side by side,
// scales by distance and adds the target with saturation.
// ----------------------------------------------------------------------------
module ocp_back #(
  parameter int CORDIC_STAGES = 18
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ocp_pkg::job_t      job_i,
  input  logic               empty_i,
  output logic               pop_o,
  output logic               valid_o,
  input  logic               ready_i,
  output logic signed [31:0] pos_x_o,
  output logic signed [31:0] pos_y_o,
  output logic signed [31:0] pos_z_o,
  output logic               clamped_o
);
  import ocp_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_ROT  = 4'b0010,
    ST_MUL  = 4'b0100,
    ST_SUM  = 4'b1000
  } state_e;

  state_e             state_q, state_d;
  job_t               job_q;
  logic               yaw_done, pitch_done, start;
  logic signed [34:0] sy, cy, sp, cp;
  logic signed [32:0] d_s;
  logic signed [67:0] ph_q, pv_q;
  logic signed [34:0] h;
  logic signed [69:0] px_q, pz_q;
  logic signed [34:0] yoff_q;
  logic signed [39:0] xoff, zoff;
  logic               out_ld;

  function automatic logic signed [31:0] sat32(input logic signed [40:0] v);
    if (v > 41'sd2147483647) return 32'sh7FFF_FFFF;
    if (v < -41'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  ocp_cordic #(.CORDIC_STAGES(CORDIC_STAGES)) u_yaw (
    .clk_i, .rst_ni, .start_i(start), .angle_i(job_i.yaw_t),
    .done_o(yaw_done), .sin_o(sy), .cos_o(cy)
  );

  ocp_cordic #(.CORDIC_STAGES(CORDIC_STAGES)) u_pitch (
    .clk_i, .rst_ni, .start_i(start), .angle_i(job_i.pitch_t),
    .done_o(pitch_done), .sin_o(sp), .cos_o(cp)
  );

  assign d_s   = $signed({1'b0, job_q.dist_v});
  assign h     = ph_q[64:30];
  assign xoff  = px_q[69:30];
  assign zoff  = pz_q[69:30];
  assign start = (state_q == ST_IDLE) && !empty_i;
  assign pop_o = start;
  assign out_ld = (state_q == ST_SUM) && (!valid_o || ready_i);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (!empty_i) state_d = ST_ROT;
      ST_ROT:  if (yaw_done && pitch_done) state_d = ST_MUL;
      ST_MUL:  state_d = ST_SUM;
      ST_SUM:  if (out_ld) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      valid_o <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_ld) begin
        valid_o <= 1'b1;
      end else if (ready_i) begin
        valid_o <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start) begin
      job_q <= job_i;
    end
    if (state_q == ST_ROT) begin
      ph_q <= 68'(d_s) * 68'(cp);
      pv_q <= 68'(d_s) * 68'(sp);
    end
    if (state_q == ST_MUL) begin
      px_q   <= 70'(h) * 70'(sy);
      pz_q   <= 70'(h) * 70'(cy);
      yoff_q <= pv_q[64:30];
    end
    if (out_ld) begin
      pos_x_o   <= sat32(41'(job_q.tx) + 41'(xoff));
      pos_y_o   <= sat32(41'(job_q.ty) + 41'(yoff_q));
      pos_z_o   <= sat32(41'(job_q.tz) + 41'(zoff));
      clamped_o <= job_q.clamped;
    end
  end

endmodule

// File: sim/orbit_camera_checker.sv
// ----------------------------------------------------------------------------
// orbit_camera_checker
// Watches the input, output and register-write channels of the orbit camera
// block, keeps its own copy of the camera state and registers, works out the
// position for every accepted item and compares each result in order.
// ----------------------------------------------------------------------------
module orbit_camera_checker (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_addr_i,
  input  logic [31:0]  cfg_wdata_i,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [175:0] s_axis_tdata,
  input  logic [1:0]   s_axis_tuser,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [95:0]  m_axis_tdata,
  input  logic [0:0]   m_axis_tuser,
  output int           fail_count_o,
  output int           pending_o
);
  import ocp_pkg::*;

  typedef struct packed {
    logic [31:0] px;
    logic [31:0] py;
    logic [31:0] pz;
    logic        clamped;
  } pos_t;

  localparam longint Quarter = 64'sd1 << 30;
  localparam longint Half    = 64'sd1 << 31;
  localparam longint AtanTab [30] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
    10, 5, 3, 1};

  logic [15:0] rot_gain;
  logic [21:0] pitch_lim;
  logic [23:0] zoom_gain;
  logic [31:0] min_dist;
  logic [31:0] tgt_x, tgt_y, tgt_z, cam_dist;
  logic [23:0] yaw, pitch;
  pos_t        expected_pos[$];
  int          fails;

  assign fail_count_o = fails;
  assign pending_o    = expected_pos.size();

  task automatic sin_cos(input logic [23:0] ang, output longint s, output longint c);
    longint z, x, y, nx;
    logic   flip;
    logic [31:0] t;
    t    = {ang, 8'd0};
    z    = longint'(signed'(t));
    x    = 652032874;
    y    = 0;
    flip = 1'b0;
    if (z > Quarter) begin
      z -= Half;
      flip = 1'b1;
    end else if (z < -Quarter) begin
      z += Half;
      flip = 1'b1;
    end
    for (int i = 0; i < CordicStagesDef; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        z -= AtanTab[i];
      end else begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        z += AtanTab[i];
      end
      x = nx;
    end
    s = flip ? -y : y;
    c = flip ? -x : x;
  endtask

  function automatic logic [31:0] sat_sum(input logic [31:0] base, input longint off);
    longint v;
    v = longint'(signed'(base)) + off;
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return v[31:0];
  endfunction

  task automatic camera_step(input logic [1:0] cmd, input logic [175:0] d);
    longint sy, cy, sp, cp, dd, hh, p, lim, nd;
    pos_t   r;
    r.clamped = 1'b0;
    if (cmd == CMD_MOTION) begin
      lim = longint'(pitch_lim);
      if (lim > (64'sd1 << 22)) lim = 64'sd1 << 22;
      yaw = yaw + 24'(longint'(signed'(d[15:0])) * longint'(rot_gain));
      p = longint'(signed'(pitch)) + longint'(signed'(d[31:16])) * longint'(rot_gain);
      if (p > lim) begin
        p = lim;
        r.clamped = 1'b1;
      end else if (p < -lim) begin
        p = -lim;
        r.clamped = 1'b1;
      end
      pitch = p[23:0];
      nd = longint'(cam_dist) - longint'(signed'(d[47:32])) * longint'(zoom_gain);
      if (nd < longint'(min_dist)) nd = longint'(min_dist);
      if (nd > 64'sd4294967295) nd = 64'sd4294967295;
      cam_dist = nd[31:0];
    end else if (cmd == CMD_TARGET || cmd == CMD_INIT) begin
      tgt_x = d[79:48];
      tgt_y = d[111:80];
      tgt_z = d[143:112];
      if (cmd == CMD_INIT) begin
        cam_dist = d[175:144];
        yaw      = '0;
        pitch    = '0;
      end
    end
    sin_cos(yaw, sy, cy);
    sin_cos(pitch, sp, cp);
    dd   = longint'(cam_dist);
    hh   = (dd * cp) >>> 30;
    r.px = sat_sum(tgt_x, (hh * sy) >>> 30);
    r.py = sat_sum(tgt_y, (dd * sp) >>> 30);
    r.pz = sat_sum(tgt_z, (hh * cy) >>> 30);
    expected_pos.push_back(r);
  endtask

  task automatic compare(input string what, input logic [31:0] e, input logic [31:0] a);
    if (e !== a) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, what, e, a);
      fails++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    pos_t e;
    if (!rst_ni) begin
      rot_gain  = RotGainRst;
      pitch_lim = PitchLimRst;
      zoom_gain = 24'd65536;
      min_dist  = 32'd65536;
      tgt_x     = '0;
      tgt_y     = '0;
      tgt_z     = '0;
      yaw       = '0;
      pitch     = '0;
      cam_dist  = 32'd327680;
      fails     = 0;
      expected_pos.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_addr_i))
          CFG_ROT_GAIN:  rot_gain  = cfg_wdata_i[15:0];
          CFG_PITCH_LIM: pitch_lim = cfg_wdata_i[21:0];
          CFG_ZOOM_GAIN: zoom_gain = cfg_wdata_i[23:0];
          CFG_MIN_DIST:  min_dist  = cfg_wdata_i;
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) camera_step(s_axis_tuser, s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_pos.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, m_axis_tdata);
          fails++;
        end else begin
          e = expected_pos.pop_front();
          compare("pos_x", e.px, m_axis_tdata[31:0]);
          compare("pos_y", e.py, m_axis_tdata[63:32]);
          compare("pos_z", e.pz, m_axis_tdata[95:64]);
          compare("pitch_clamped", 32'(e.clamped), 32'(m_axis_tuser[0]));
        end
      end
    end
  end

endmodule

// File: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives the orbit camera block with directed and random command items and
// register settings under random idling and back-pressure; the checker beside
// it predicts every position, and the verdict is given here.
// ----------------------------------------------------------------------------
module tb_top;
  import ocp_pkg::*;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         cfg_we_i = 1'b0;
  logic [1:0]   cfg_addr_i = '0;
  logic [31:0]  cfg_wdata_i = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [175:0] s_axis_tdata = '0;
  logic [1:0]   s_axis_tuser = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [95:0]  m_axis_tdata;
  logic [0:0]   m_axis_tuser;
  int           fail_count, pending;
  int           cycles = 0;
  int           sink_idle_pct = 33;
  int           sink_hold = 0;
  int           src_idle_pct = 33;

  localparam int CycleLimit = 400000;

  always #6 clk_i = ~clk_i;

  orbit_camera_position dut (.*);

  orbit_camera_checker chk (.*, .fail_count_o(fail_count), .pending_o(pending));

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (sink_hold > 0) begin
      sink_hold     <= sink_hold - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  task automatic reg_write(input cfg_idx_e idx, input logic [31:0] val);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic drain;
    while (pending != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  // one item; valid may drop for random idling before the item is offered
  task automatic send_item(input cmd_e cmd, input logic [175:0] d);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= d;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  function automatic logic [175:0] pack(input logic [15:0] dx, input logic [15:0] dy,
                                        input logic [15:0] wh, input logic [31:0] x,
                                        input logic [31:0] y, input logic [31:0] z,
                                        input logic [31:0] init_d);
    return {init_d, z, y, x, wh, dy, dx};
  endfunction

  function automatic logic [175:0] rand_bits;
    return {$urandom, $urandom, $urandom, $urandom, $urandom, 16'($urandom)};
  endfunction

  task automatic random_motion(input int n, input int span);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(19) == 0)
        send_item(cmd_e'($urandom_range(3)), rand_bits());
      else if ($urandom_range(9) == 0)
        send_item(CMD_MOTION, rand_bits());
      else
        send_item(CMD_MOTION, pack(16'($signed($urandom_range(2 * span)) - span),
                                   16'($signed($urandom_range(2 * span)) - span),
                                   16'($signed($urandom_range(2 * span)) - span),
                                   '0, '0, '0, '0));
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_item(CMD_MOTION, '0);
    send_item(CMD_MOTION, pack(16'h7fff, 16'h7fff, 16'h7fff, '0, '0, '0, '0));
    send_item(CMD_MOTION, pack(16'h8000, 16'h8000, 16'h8000, '0, '0, '0, '0));
    send_item(CMD_MOTION, pack(16'h0001, 16'hffff, 16'h8000, '0, '0, '0, '0));
    send_item(CMD_TARGET, pack('0, '0, '0, 32'h7fffffff, 32'h80000000, 32'h7fffffff, '0));
    send_item(CMD_MOTION, pack(16'h1234, 16'h0100, 16'h0000, '0, '0, '0, '0));
    send_item(CMD_INIT, pack('1, '1, '1, 32'h80000000, 32'h7fffffff, 32'h80000000, '1));
    send_item(CMD_MOTION, pack(16'h4000, 16'h0000, 16'h0000, '0, '0, '0, '0));
    send_item(CMD_NONE, rand_bits());
    send_item(CMD_INIT, pack('0, '0, '0, '0, '0, '0, '0));
    send_item(CMD_MOTION, pack(16'h0000, 16'h0000, 16'h0000, '0, '0, '0, '0));
    send_item(CMD_INIT, pack('0, '0, '0, 32'h10000, 32'hfff00000, 32'h20000, 32'h40000));
    s_axis_tvalid <= 1'b0;
    drain();

    reg_write(CFG_ROT_GAIN, 32'hffff);
    reg_write(CFG_PITCH_LIM, 32'h3fffff);
    reg_write(CFG_ZOOM_GAIN, 32'hffffff);
    reg_write(CFG_MIN_DIST, 32'hffffffff);
    send_item(CMD_MOTION, pack(16'h7fff, 16'h7fff, 16'h8000, '0, '0, '0, '0));
    send_item(CMD_MOTION, pack(16'h8000, 16'h8000, 16'h7fff, '0, '0, '0, '0));
    send_item(CMD_MOTION, pack(16'h0003, 16'h0001, 16'h0000, '0, '0, '0, '0));
    s_axis_tvalid <= 1'b0;
    drain();

    reg_write(CFG_ROT_GAIN, 32'd0);
    reg_write(CFG_PITCH_LIM, 32'd0);
    reg_write(CFG_ZOOM_GAIN, 32'd0);
    reg_write(CFG_MIN_DIST, 32'd0);
    send_item(CMD_MOTION, pack(16'h7fff, 16'h8000, 16'h7fff, '0, '0, '0, '0));
    send_item(CMD_INIT, pack('0, '0, '0, '0, '0, '0, 32'h12345));
    send_item(CMD_MOTION, pack(16'h0001, 16'h0001, 16'h7fff, '0, '0, '0, '0));
    s_axis_tvalid <= 1'b0;
    drain();

    // long back-pressure: the block fills and stalls its input
    sink_hold <= 300;
    random_motion(20, 200);
    s_axis_tvalid <= 1'b0;
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      reg_write(CFG_ROT_GAIN, $urandom_range(65535));
      reg_write(CFG_PITCH_LIM, $urandom_range(4194303));
      reg_write(CFG_ZOOM_GAIN, $urandom_range(16777215));
      reg_write(CFG_MIN_DIST, (ph % 2) ? $urandom : $urandom_range(1 << 20));
      if (ph == 2) begin
        src_idle_pct  = 0;
        sink_idle_pct = 0;
      end else begin
        src_idle_pct  = 33;
        sink_idle_pct = 33;
      end
      send_item(CMD_INIT, pack('0, '0, '0, $urandom, $urandom, $urandom,
                               $urandom_range(1 << 24)));
      random_motion(205, (ph % 3 == 0) ? 32767 : 300);
      s_axis_tvalid <= 1'b0;
      drain();
    end

    reg_write(CFG_ROT_GAIN, 32'(RotGainRst));
    reg_write(CFG_PITCH_LIM, 32'(PitchLimRst));
    reg_write(CFG_ZOOM_GAIN, 32'd65536);
    reg_write(CFG_MIN_DIST, 32'd65536);
    random_motion(30, 100);
    s_axis_tvalid <= 1'b0;
    drain();

    if (fail_count == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
